FILE: rtl/core/u16ver_pkg.sv
// Shared constants, types and helpers for the UTF-16 version-marker scanner.
// Used by the extractor, scanner and emitter files under rtl/core; depends on nothing.
package u16ver_pkg;

	localparam int MaxLen    = 20;
	localparam int ResultCap = 20;
	localparam int LimCap    = (MaxLen < ResultCap) ? MaxLen : ResultCap;
	localparam int CntW      = $clog2(MaxLen + 1);
	localparam int IdxW      = (MaxLen > 1) ? $clog2(MaxLen) : 1;
	localparam int CfgW      = 5;
	localparam int WinDepth  = 27;
	localparam int MarkChars = 14;

	localparam logic [MarkChars*8-1:0] MarkerStr = "ProductVersion";

	localparam logic [1:0] ModeSearch  = 2'd0;
	localparam logic [1:0] ModeCollect = 2'd1;
	localparam logic [1:0] ModeDone    = 2'd2;

	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StNotFound = 2'd1;
	localparam logic [1:0] StTooLong  = 2'd2;

	localparam logic [7:0] ChDot  = 8'h2e;
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChNine = 8'h39;

	// Report request from the scanner to the emitter
	typedef struct packed {
		logic            valid;
		logic            single;
		logic            burst;
		logic [1:0]      status;
		logic [CntW-1:0] len;
	} u16ver_rpt_t;

	// Expected byte at window position p: marker character at even
	// positions, zero high byte at odd positions.
	function automatic logic [7:0] expected_at(input int p);
		logic [7:0] ch;
		ch = MarkerStr[(MarkChars - 1 - (p >> 1)) * 8 +: 8];
		return p[0] ? 8'h00 : ch;
	endfunction

	function automatic logic is_version_char(input logic [7:0] b);
		return (b == ChDot) || ((b >= ChZero) && (b <= ChNine));
	endfunction

endpackage

FILE: rtl/core/u16ver_if.sv
// Handshake channel interfaces for the version-marker scanner.
// Depends on nothing; u16ver_pkg is not needed here.
interface u16ver_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;
	modport source(output valid, data_byte, end_of_file, input ready);
	modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface u16ver_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] version_char;
	logic       char_valid;
	logic       last_of_run;
	modport source(output valid, status, version_char, char_valid, last_of_run, input ready);
	modport sink(input valid, status, version_char, char_valid, last_of_run, output ready);
endinterface

interface u16ver_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] max_version_length;
	modport source(output valid, max_version_length, input ready);
	modport sink(input valid, max_version_length, output ready);
endinterface

FILE: rtl/core/utf16_marker_version_extractor.sv
// Flow: a byte is registered, then scanned; a one-result report is loaded into the result
// register; a burst request sets the burst sequencer, which gives one char a cycle
// while the output is ready. Throughput: one byte per cycle while the output is free;
// input stalls while a burst drains, set by the single read port of the version store.
// Reset: arst_n clears the window, mode, count and output valid; limit returns to 20.
// Version store contents are not reset.
module utf16_marker_version_extractor (
	input  logic          clk,
	input  logic          arst_n,
	u16ver_in_if.sink     bytes,
	u16ver_cfg_if.sink    cfg,
	u16ver_out_if.source  report
);

	logic [u16ver_pkg::CfgW-1:0] max_len_q;
	logic [u16ver_pkg::CntW-1:0] lim;
	logic                        take;
	logic [u16ver_pkg::IdxW-1:0] rd_idx;
	logic [7:0]                  rd_char;
	u16ver_pkg::u16ver_rpt_t     rpt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= u16ver_pkg::CfgW'(20);
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_version_length;
		end
	end

	// clamp the limit to the store depth
	assign lim = ({1'b0, max_len_q} > (u16ver_pkg::CfgW+1)'(u16ver_pkg::LimCap))
		? u16ver_pkg::CntW'(u16ver_pkg::LimCap) : u16ver_pkg::CntW'(max_len_q);

	u16ver_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.lim     (lim),
		.take    (take),
		.rd_idx  (rd_idx),
		.rd_char (rd_char),
		.rpt     (rpt)
	);

	u16ver_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.rpt     (rpt),
		.take    (take),
		.rd_idx  (rd_idx),
		.rd_char (rd_char),
		.report  (report)
	);

	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.burst |=> !take)
		else $error("scanner not held after burst request");

	a_single_shown: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.single |=> report.valid && report.last_of_run && !report.char_valid)
		else $error("single report not loaded");

	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && report.char_valid |->
		report.status == u16ver_pkg::StOk && u16ver_pkg::is_version_char(report.version_char))
		else $error("bad version character");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> report.status == u16ver_pkg::StOk ||
		report.status == u16ver_pkg::StNotFound || report.status == u16ver_pkg::StTooLong)
		else $error("undefined status code");

endmodule

FILE: rtl/core/u16ver_scan.sv
// Input register, sliding marker window, collect state and version store.
// Depends on u16ver_pkg and u16ver_in_if.
module u16ver_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	u16ver_in_if.sink                       bytes,
	input  logic [u16ver_pkg::CntW-1:0]     lim,
	input  logic                            take,
	input  logic [u16ver_pkg::IdxW-1:0]     rd_idx,
	output logic [7:0]                      rd_char,
	output u16ver_pkg::u16ver_rpt_t         rpt
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        eof_s1;
	logic                        consume;

	logic [7:0]                  window_q [u16ver_pkg::WinDepth];
	logic [1:0]                  mode_q;
	logic [u16ver_pkg::CntW-1:0] count_q;
	logic [7:0]                  store_q [u16ver_pkg::MaxLen];

	logic                        hit;
	logic                        shift;
	logic                        wr_en;
	logic [1:0]                  mode_n;
	logic [u16ver_pkg::CntW-1:0] count_n;
	u16ver_pkg::u16ver_rpt_t     rpt_c;

	function automatic u16ver_pkg::u16ver_rpt_t version_rpt(
		input logic [u16ver_pkg::CntW-1:0] cnt,
		input logic [u16ver_pkg::CntW-1:0] lm
	);
		u16ver_pkg::u16ver_rpt_t r;
		logic [u16ver_pkg::CntW-1:0] n;
		n        = (cnt > lm) ? lm : cnt;
		r        = '0;
		r.status = u16ver_pkg::StOk;
		r.len    = n;
		if (n == '0) r.single = 1'b1;
		else         r.burst  = 1'b1;
		return r;
	endfunction

	assign consume     = valid_s1 & take;
	assign bytes.ready = !valid_s1 || take;
	assign rd_char     = store_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			eof_s1  <= bytes.end_of_file;
		end
	end

	always_comb begin
		hit = (byte_s1 == u16ver_pkg::expected_at(u16ver_pkg::WinDepth));
		for (int p = 0; p < u16ver_pkg::WinDepth; p++) begin
			if (window_q[p] != u16ver_pkg::expected_at(p)) hit = 1'b0;
		end
	end

	always_comb begin
		rpt_c   = '0;
		shift   = 1'b0;
		wr_en   = 1'b0;
		mode_n  = mode_q;
		count_n = count_q;
		unique case (mode_q)
			u16ver_pkg::ModeSearch: begin
				shift = 1'b1;
				if (hit && !eof_s1) begin
					mode_n  = u16ver_pkg::ModeCollect;
					count_n = '0;
				end else if (eof_s1) begin
					rpt_c.single = 1'b1;
					rpt_c.status = u16ver_pkg::StNotFound;
				end
			end
			u16ver_pkg::ModeCollect: begin
				if (byte_s1 == 8'h00) begin
					// skip the zero high byte
				end else if (u16ver_pkg::is_version_char(byte_s1)) begin
					if (count_q >= lim) begin
						rpt_c.single = 1'b1;
						rpt_c.status = u16ver_pkg::StTooLong;
						mode_n       = u16ver_pkg::ModeDone;
					end else begin
						wr_en   = 1'b1;
						count_n = count_q + u16ver_pkg::CntW'(1);
					end
				end else begin
					rpt_c  = version_rpt(count_q, lim);
					mode_n = u16ver_pkg::ModeDone;
				end
				if (eof_s1 && mode_n == u16ver_pkg::ModeCollect) begin
					rpt_c = version_rpt(count_n, lim);
				end
			end
			default: begin
				// done: ignore the rest of the file
			end
		endcase
		if (eof_s1) begin
			mode_n  = u16ver_pkg::ModeSearch;
			count_n = '0;
		end
		rpt_c.valid = consume;
	end

	assign rpt = rpt_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= u16ver_pkg::ModeSearch;
			count_q <= '0;
			for (int p = 0; p < u16ver_pkg::WinDepth; p++) window_q[p] <= 8'h00;
		end else if (consume) begin
			mode_q  <= mode_n;
			count_q <= count_n;
			if (eof_s1) begin
				for (int p = 0; p < u16ver_pkg::WinDepth; p++) window_q[p] <= 8'h00;
			end else if (shift) begin
				for (int p = 0; p < u16ver_pkg::WinDepth - 1; p++) window_q[p] <= window_q[p+1];
				window_q[u16ver_pkg::WinDepth-1] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && wr_en) begin
			store_q[count_q[u16ver_pkg::IdxW-1:0]] <= byte_s1;
		end
	end

endmodule

FILE: rtl/core/u16ver_emit.sv
// Result register and burst sequencer that reads the version store out.
// Depends on u16ver_pkg and u16ver_out_if.
module u16ver_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  u16ver_pkg::u16ver_rpt_t         rpt,
	output logic                            take,
	output logic [u16ver_pkg::IdxW-1:0]     rd_idx,
	input  logic [7:0]                      rd_char,
	u16ver_out_if.source                    report
);

	logic                        out_valid_q;
	logic                        burst_q;
	logic [u16ver_pkg::IdxW-1:0] idx_q;
	logic [u16ver_pkg::CntW-1:0] len_q;
	logic [1:0]                  status_q;
	logic [7:0]                  char_q;
	logic                        char_valid_q;
	logic                        last_q;
	logic                        out_free;
	logic                        burst_last;

	assign out_free   = !out_valid_q || report.ready;
	assign take       = !burst_q && out_free;
	assign rd_idx     = idx_q;
	assign burst_last = (u16ver_pkg::CntW'(idx_q) + u16ver_pkg::CntW'(1)) == len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			burst_q     <= 1'b0;
			idx_q       <= '0;
		end else if (burst_q && out_free) begin
			out_valid_q <= 1'b1;
			idx_q       <= idx_q + u16ver_pkg::IdxW'(1);
			if (burst_last) burst_q <= 1'b0;
		end else if (rpt.valid && rpt.single) begin
			out_valid_q <= 1'b1;
		end else begin
			if (rpt.valid && rpt.burst) begin
				burst_q <= 1'b1;
				idx_q   <= '0;
			end
			if (report.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_q && out_free) begin
			status_q     <= u16ver_pkg::StOk;
			char_q       <= rd_char;
			char_valid_q <= 1'b1;
			last_q       <= burst_last;
		end else if (rpt.valid && rpt.single) begin
			status_q     <= rpt.status;
			char_q       <= 8'h00;
			char_valid_q <= 1'b0;
			last_q       <= 1'b1;
		end
		if (rpt.valid && rpt.burst) len_q <= rpt.len;
	end

	assign report.valid        = out_valid_q;
	assign report.status       = status_q;
	assign report.version_char = char_q;
	assign report.char_valid   = char_valid_q;
	assign report.last_of_run  = last_q;

endmodule
